// ----- design/odrgb_pkg.sv -----
`timescale 1ns / 1ps

package odrgb_pkg;

  // channel limits
  localparam logic [7:0] CH_MAX = 8'd255;

  // reciprocal format: ceil(2^RCP_SHIFT / d), exact for numerators below 2^9
  localparam int RCP_SHIFT = 17;
  localparam int RCP_W     = RCP_SHIFT + 1;
  localparam int RCP_ONE   = 2 ** RCP_SHIFT;

  // coefficients that follow from levels after reset
  localparam int               RESET_LEVELS   = 32;
  localparam logic [7:0]       RESET_STEP     = 8'(255 / RESET_LEVELS);
  localparam logic [RCP_W-1:0] RESET_RCP_LV   = RCP_W'((RCP_ONE + RESET_LEVELS - 1)
                                                        / RESET_LEVELS);
  localparam logic [RCP_W-1:0] RESET_RCP_STEP = RCP_W'((RCP_ONE + int'(RESET_STEP) - 1)
                                                        / int'(RESET_STEP));

  // coefficient sequencer states
  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_DIV_LV,
    SEQ_STEP,
    SEQ_DIV_STEP
  } seq_e;

  // coefficients handed to the pixel pipeline
  typedef struct packed {
    logic [RCP_W-1:0] rcp_lv;
    logic [7:0]       step;
    logic [RCP_W-1:0] rcp_step;
  } coef_t;

  // 16x16 bayer threshold matrix, indexed by {y[3:0], x[3:0]}
  localparam logic [7:0] DITHER_ROM [256] = '{
    8'd0, 8'd191, 8'd48, 8'd239, 8'd12, 8'd203, 8'd60, 8'd251,
    8'd3, 8'd194, 8'd51, 8'd242, 8'd15, 8'd206, 8'd63, 8'd254,
    8'd127, 8'd64, 8'd175, 8'd112, 8'd139, 8'd76, 8'd187, 8'd124,
    8'd130, 8'd67, 8'd178, 8'd115, 8'd142, 8'd79, 8'd190, 8'd127,
    8'd32, 8'd223, 8'd16, 8'd207, 8'd44, 8'd235, 8'd28, 8'd219,
    8'd35, 8'd226, 8'd19, 8'd210, 8'd47, 8'd238, 8'd31, 8'd222,
    8'd159, 8'd96, 8'd143, 8'd80, 8'd171, 8'd108, 8'd155, 8'd92,
    8'd162, 8'd99, 8'd146, 8'd83, 8'd174, 8'd111, 8'd158, 8'd95,
    8'd8, 8'd199, 8'd56, 8'd247, 8'd4, 8'd195, 8'd52, 8'd243,
    8'd11, 8'd202, 8'd59, 8'd250, 8'd7, 8'd198, 8'd55, 8'd246,
    8'd135, 8'd72, 8'd183, 8'd120, 8'd131, 8'd68, 8'd179, 8'd116,
    8'd138, 8'd75, 8'd186, 8'd123, 8'd134, 8'd71, 8'd182, 8'd119,
    8'd40, 8'd231, 8'd24, 8'd215, 8'd36, 8'd227, 8'd20, 8'd211,
    8'd43, 8'd234, 8'd27, 8'd218, 8'd39, 8'd230, 8'd23, 8'd214,
    8'd167, 8'd104, 8'd151, 8'd88, 8'd163, 8'd100, 8'd147, 8'd84,
    8'd170, 8'd107, 8'd154, 8'd91, 8'd166, 8'd103, 8'd150, 8'd87,
    8'd2, 8'd193, 8'd50, 8'd241, 8'd14, 8'd205, 8'd62, 8'd253,
    8'd1, 8'd192, 8'd49, 8'd240, 8'd13, 8'd204, 8'd61, 8'd252,
    8'd129, 8'd66, 8'd177, 8'd114, 8'd141, 8'd78, 8'd189, 8'd126,
    8'd128, 8'd65, 8'd176, 8'd113, 8'd140, 8'd77, 8'd188, 8'd125,
    8'd34, 8'd225, 8'd18, 8'd209, 8'd46, 8'd237, 8'd30, 8'd221,
    8'd33, 8'd224, 8'd17, 8'd208, 8'd45, 8'd236, 8'd29, 8'd220,
    8'd161, 8'd98, 8'd145, 8'd82, 8'd173, 8'd110, 8'd157, 8'd94,
    8'd160, 8'd97, 8'd144, 8'd81, 8'd172, 8'd109, 8'd156, 8'd93,
    8'd10, 8'd201, 8'd58, 8'd249, 8'd6, 8'd197, 8'd54, 8'd245,
    8'd9, 8'd200, 8'd57, 8'd248, 8'd5, 8'd196, 8'd53, 8'd244,
    8'd137, 8'd74, 8'd185, 8'd122, 8'd133, 8'd70, 8'd181, 8'd118,
    8'd136, 8'd73, 8'd184, 8'd121, 8'd132, 8'd69, 8'd180, 8'd117,
    8'd42, 8'd233, 8'd26, 8'd217, 8'd38, 8'd229, 8'd22, 8'd213,
    8'd41, 8'd232, 8'd25, 8'd216, 8'd37, 8'd228, 8'd21, 8'd212,
    8'd169, 8'd106, 8'd153, 8'd90, 8'd165, 8'd102, 8'd149, 8'd86,
    8'd168, 8'd105, 8'd152, 8'd89, 8'd164, 8'd101, 8'd148, 8'd85
  };

endpackage

// ----- design/odrgb_recip.sv -----
`timescale 1ns / 1ps

module odrgb_recip (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [7:0]          cfg_levels_i,
  output logic                cfg_ready_o,
  output logic                busy_o,
  output odrgb_pkg::coef_t    coef_o
);

  localparam int CntW = $clog2(odrgb_pkg::RCP_SHIFT);

  odrgb_pkg::seq_e state_q, state_d;

  logic [CntW-1:0]                 cnt_q, cnt_d;
  logic [7:0]                      rem_q, rem_d;
  logic [odrgb_pkg::RCP_SHIFT-1:0] quo_q, quo_d;
  logic [7:0]                      div_q, div_d;
  odrgb_pkg::coef_t                coef_q, coef_d;

  logic                            write;
  logic                            last;
  logic [8:0]                      trial;
  logic                            ge;
  logic [7:0]                      rem_step;
  logic [odrgb_pkg::RCP_SHIFT-1:0] quo_step;
  logic [odrgb_pkg::RCP_W-1:0]     rcp_new;
  logic [odrgb_pkg::RCP_W+7:0]     step_prod;

  // write accepted only when the sequencer rests
  assign write = cfg_valid_i && cfg_ready_o;
  assign last  = (cnt_q == CntW'(odrgb_pkg::RCP_SHIFT - 1));

  // one restoring division step on the all-ones numerator 2^17 - 1
  always_comb begin
    trial    = {rem_q, 1'b1};
    ge       = (trial >= {1'b0, div_q});
    rem_step = ge ? 8'(trial - {1'b0, div_q}) : trial[7:0];
    quo_step = {quo_q[odrgb_pkg::RCP_SHIFT-2:0], ge};
    rcp_new  = {1'b0, quo_step} + odrgb_pkg::RCP_W'(1);
  end

  // step = floor(255 / lv) from the reciprocal of lv
  assign step_prod = (odrgb_pkg::RCP_W + 8)'(odrgb_pkg::CH_MAX)
                   * (odrgb_pkg::RCP_W + 8)'(coef_q.rcp_lv);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      odrgb_pkg::SEQ_IDLE: begin
        if (write) state_d = odrgb_pkg::SEQ_DIV_LV;
      end
      odrgb_pkg::SEQ_DIV_LV: begin
        if (last) state_d = odrgb_pkg::SEQ_STEP;
      end
      odrgb_pkg::SEQ_STEP: begin
        state_d = odrgb_pkg::SEQ_DIV_STEP;
      end
      odrgb_pkg::SEQ_DIV_STEP: begin
        if (last) state_d = odrgb_pkg::SEQ_IDLE;
      end
      default: begin
        state_d = odrgb_pkg::SEQ_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    case (state_q)
      odrgb_pkg::SEQ_IDLE: begin
        busy_o      = 1'b0;
        cfg_ready_o = 1'b1;
      end
      default: begin
        busy_o      = 1'b1;
        cfg_ready_o = 1'b0;
      end
    endcase
  end

  // divider datapath and coefficient updates
  always_comb begin
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    coef_d = coef_q;
    case (state_q)
      odrgb_pkg::SEQ_IDLE: begin
        if (write) begin
          // levels of zero behaves as one
          div_d = (cfg_levels_i == 8'd0) ? 8'd1 : cfg_levels_i;
          cnt_d = '0;
          rem_d = '0;
          quo_d = '0;
        end
      end
      odrgb_pkg::SEQ_DIV_LV: begin
        cnt_d = cnt_q + CntW'(1);
        rem_d = rem_step;
        quo_d = quo_step;
        if (last) coef_d.rcp_lv = rcp_new;
      end
      odrgb_pkg::SEQ_STEP: begin
        coef_d.step = step_prod[odrgb_pkg::RCP_SHIFT+7:odrgb_pkg::RCP_SHIFT];
        div_d       = step_prod[odrgb_pkg::RCP_SHIFT+7:odrgb_pkg::RCP_SHIFT];
        cnt_d       = '0;
        rem_d       = '0;
        quo_d       = '0;
      end
      odrgb_pkg::SEQ_DIV_STEP: begin
        cnt_d = cnt_q + CntW'(1);
        rem_d = rem_step;
        quo_d = quo_step;
        if (last) coef_d.rcp_step = rcp_new;
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  // sequencer and coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= odrgb_pkg::SEQ_IDLE;
      cnt_q           <= '0;
      coef_q.rcp_lv   <= odrgb_pkg::RESET_RCP_LV;
      coef_q.step     <= odrgb_pkg::RESET_STEP;
      coef_q.rcp_step <= odrgb_pkg::RESET_RCP_STEP;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      coef_q  <= coef_d;
    end
  end

  // divider working registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign coef_o = coef_q;

endmodule

// ----- design/odrgb_pipe.sv -----
`timescale 1ns / 1ps

module odrgb_pipe (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  odrgb_pkg::coef_t  coef_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [3:0]        pos_x_i,
  input  logic [3:0]        pos_y_i,
  input  logic [23:0]       color_in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [23:0]       color_out_o
);

  localparam int Sh    = odrgb_pkg::RCP_SHIFT;
  localparam int OffW  = odrgb_pkg::RCP_W + 8;
  localparam int QuoW  = odrgb_pkg::RCP_W + 9;

  logic en1, en2, en3, en4;
  logic v1_q, v2_q, v3_q, v4_q;

  logic [7:0]             t1_q;
  logic [23:0]            c1_q, c2_q;
  logic [OffW-1:0]        off2_q;
  logic [2:0][QuoW-1:0]   m3_q;
  logic [23:0]            out4_q;

  logic [7:0]             off;
  logic [2:0][8:0]        sum;
  logic [2:0][QuoW-1:0]   m3_d;
  logic [2:0][8:0]        quo;
  logic [2:0][16:0]       qs;
  logic [23:0]            out4_d;

  // a stage moves when it is empty or the one after it moves
  assign en4        = !v4_q || !out_stall_i;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_stall_o = !en1;

  // stage 3 input: offset from stage 2 and per-channel quotient product
  always_comb begin
    off = off2_q[Sh+7:Sh];
    for (int i = 0; i < 3; i++) begin
      sum[i]  = {1'b0, c2_q[8*i +: 8]} + {1'b0, off};
      m3_d[i] = QuoW'(sum[i]) * QuoW'(coef_i.rcp_step);
    end
  end

  // stage 4 input: back to the step grid, saturate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      quo[i] = m3_q[i][Sh+8:Sh];
      qs[i]  = 17'(quo[i]) * 17'(coef_i.step);
      out4_d[8*i +: 8] = (qs[i] > 17'(odrgb_pkg::CH_MAX)) ? odrgb_pkg::CH_MAX : qs[i][7:0];
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (en1) begin
      t1_q <= odrgb_pkg::DITHER_ROM[{pos_y_i, pos_x_i}];
      c1_q <= color_in_i;
    end
    if (en2) begin
      off2_q <= OffW'(t1_q) * OffW'(coef_i.rcp_lv);
      c2_q   <= c1_q;
    end
    if (en3) m3_q <= m3_d;
    if (en4) out4_q <= out4_d;
  end

  assign out_valid_o = v4_q;
  assign color_out_o = out4_q;

endmodule

// ----- design/ordered_dither_rgb_top.sv -----
`timescale 1ns / 1ps
// ordered bayer dither, one rgb pixel per item through four register stages
// each item's result is registered in stage 1, 2, 3 and 4 in turn, then drives color_out_o
// throughput: one item per cycle, set by the four-stage multiply pipeline, while
// out_stall_i is low; a levels write keeps in_stall_o high while the serial divider
// rebuilds the reciprocals; reset empties the pipeline and sets levels to 32

module ordered_dither_rgb_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_levels_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [23:0] color_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [23:0] color_out_o
);

  odrgb_pkg::coef_t coef;
  logic             busy;
  logic             pipe_stall;

  // coefficient sequencer
  odrgb_recip u_recip (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_levels_i (cfg_levels_i),
    .cfg_ready_o  (cfg_ready_o),
    .busy_o       (busy),
    .coef_o       (coef)
  );

  // pixel pipeline, held off while coefficients are rebuilt
  odrgb_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_i      (coef),
    .in_valid_i  (in_valid_i && !busy),
    .in_stall_o  (pipe_stall),
    .pos_x_i     (pos_x_i[3:0]),
    .pos_y_i     (pos_y_i[3:0]),
    .color_in_i  (color_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .color_out_o (color_out_o)
  );

  assign in_stall_o = pipe_stall || busy;

endmodule
